>>> rtl/pbd_pkg.sv
// Shared types and constants for the push-button debouncer.
package pbd_pkg;

  localparam int unsigned TS_W  = 32;
  localparam int unsigned DEB_W = 20;

  localparam logic OP_START = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  localparam logic REG_DEBOUNCE_US = 1'b0;
  localparam logic REG_ACTIVE_LOW  = 1'b1;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(20000);

  localparam logic [1:0] NTF_NONE   = 2'd0;
  localparam logic [1:0] NTF_CHANGE = 2'd1;
  localparam logic [1:0] NTF_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SHORTED = 2'd1;
  localparam logic [1:0] ERR_UNINIT  = 2'd2;

  typedef enum logic [5:0] {
    MODE_UNINIT      = 6'b000001,
    MODE_RELEASED    = 6'b000010,
    MODE_PRESS_DEB   = 6'b000100,
    MODE_PRESSED     = 6'b001000,
    MODE_RELEASE_DEB = 6'b010000,
    MODE_FAULT       = 6'b100000
  } mode_e;

  typedef struct packed {
    logic            pressed;
    logic [TS_W-1:0] held_us;
    logic [1:0]      notify;
    logic [1:0]      error;
  } pbd_result_t;

endpackage

>>> rtl/pbd_if.sv
// Handshake interfaces for the debouncer input and result channels.
interface pbd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        pin_level;
  logic [31:0] now_us;

  modport source (output valid, output op, output pin_level, output now_us, input ready);
  modport sink (input valid, input op, input pin_level, input now_us, output ready);
endinterface

interface pbd_out_if;
  logic        valid;
  logic        ready;
  logic        pressed;
  logic [31:0] held_us;
  logic [1:0]  notify;
  logic [1:0]  error;

  modport source (output valid, output pressed, output held_us, output notify, output error,
                  input ready);
  modport sink (input valid, input pressed, input held_us, input notify, input error,
                output ready);
endinterface

>>> rtl/pbd_core.sv
// Debounce state machine, configuration registers and per-item result logic.
module pbd_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [pbd_pkg::DEB_W-1:0]    cfg_data_i,
  input  logic                         step_i,
  input  logic                         op_i,
  input  logic                         pin_level_i,
  input  logic [pbd_pkg::TS_W-1:0]     now_us_i,
  output pbd_pkg::pbd_result_t         res_o
);
  import pbd_pkg::*;

  localparam int unsigned NW = (TIME_WIDTH < TS_W) ? TIME_WIDTH : TS_W;

  logic [DEB_W-1:0]      debounce_q;
  logic                  active_low_q;
  mode_e                 mode_q, mode_d;
  logic [TIME_WIDTH-1:0] deadline_q, deadline_d;
  logic [TIME_WIDTH-1:0] press_start_q, press_start_d;
  logic                  pressed_q, pressed_d;
  logic [TIME_WIDTH-1:0] held_q, held_d;

  logic                  level;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] arm_deadline;
  logic                  expired;
  logic [1:0]            notify;
  logic [1:0]            error;

  assign level        = pin_level_i ^ active_low_q;
  assign now_t        = TIME_WIDTH'(now_us_i[NW-1:0]);
  assign arm_deadline = now_t + TIME_WIDTH'(debounce_q);
  assign expired      = now_t > deadline_q;

  always_comb begin
    mode_d        = mode_q;
    deadline_d    = deadline_q;
    press_start_d = press_start_q;
    pressed_d     = pressed_q;
    held_d        = held_q;
    notify        = NTF_NONE;
    error         = ERR_NONE;
    if (op_i == OP_START) begin
      if (level) begin
        mode_d = MODE_FAULT;
        error  = ERR_SHORTED;
      end else begin
        mode_d = MODE_RELEASED;
      end
    end else begin
      case (mode_q)
        MODE_UNINIT: begin
          mode_d    = MODE_FAULT;
          notify    = NTF_ERROR;
          error     = ERR_UNINIT;
          pressed_d = 1'b0;
          held_d    = '0;
        end
        MODE_RELEASED: begin
          if (level) begin
            deadline_d = arm_deadline;
            mode_d     = MODE_PRESS_DEB;
          end
        end
        MODE_PRESS_DEB: begin
          if (level && expired) begin
            deadline_d    = '1;
            pressed_d     = 1'b1;
            held_d        = '0;
            press_start_d = now_t;
            notify        = NTF_CHANGE;
            mode_d        = MODE_PRESSED;
          end else if (!level) begin
            deadline_d = '1;
            mode_d     = MODE_RELEASED;
          end
        end
        MODE_PRESSED: begin
          if (!level) begin
            deadline_d = arm_deadline;
            mode_d     = MODE_RELEASE_DEB;
          end else begin
            held_d = now_t - press_start_q;
          end
        end
        MODE_RELEASE_DEB: begin
          if (!level && expired) begin
            deadline_d = '1;
            pressed_d  = 1'b0;
            held_d     = '0;
            notify     = NTF_CHANGE;
            mode_d     = MODE_RELEASED;
          end else if (level) begin
            deadline_d = '1;
            mode_d     = MODE_PRESSED;
          end
        end
        default: begin
          mode_d    = MODE_FAULT;
          pressed_d = 1'b0;
          held_d    = '0;
        end
      endcase
    end
  end

  assign res_o.pressed = pressed_d;
  assign res_o.held_us = TS_W'(held_d[NW-1:0]);
  assign res_o.notify  = notify;
  assign res_o.error   = error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      active_low_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DEBOUNCE_US) begin
        debounce_q <= cfg_data_i;
      end else begin
        active_low_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_UNINIT;
      deadline_q    <= '1;
      press_start_q <= '0;
      pressed_q     <= 1'b0;
      held_q        <= '0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      deadline_q    <= deadline_d;
      press_start_q <= press_start_d;
      pressed_q     <= pressed_d;
      held_q        <= held_d;
    end
  end

endmodule

>>> rtl/push_button_debouncer.sv
// Top level of the push-button debouncer: state machine plus buffered result channel.
//
// Usage:
//   in_i carries one item per handshake: op (0 start check, 1 poll), the raw
//   pin level and a microsecond timestamp. Every accepted item yields exactly
//   one result item on out_o: debounced pressed flag, hold time, notify code
//   and error code. Results leave in input order.
//   Each result is registered in the output register, or in the skid entry while that one waits.
//   Throughput is one item per cycle while in_i.ready is high; the state updates on each accepted item.
//   The result side has an output register plus one skid entry, so an item is
//   still accepted while one result waits; in_i.ready drops only when both are
//   full, and rises again the cycle after out_o takes a result.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 debounce time in us, 1 active-low pin). Write only while idle.
//   Reset (rst_ni low, asynchronous) returns the machine to uninitialized,
//   restores the register defaults (20000 us, active high) and empties the
//   result buffer. A poll before any start check reports an error.
module push_button_debouncer #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [pbd_pkg::DEB_W-1:0] cfg_data_i,
  pbd_in_if.sink                    in_i,
  pbd_out_if.source                 out_o
);
  import pbd_pkg::*;

  pbd_result_t res;
  pbd_result_t out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_fire, out_fire;

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  pbd_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_fire),
    .op_i       (in_i.op),
    .pin_level_i(in_i.pin_level),
    .now_us_i   (in_i.now_us),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pressed = out_q.pressed;
  assign out_o.held_us = out_q.held_us;
  assign out_o.notify  = out_q.notify;
  assign out_o.error   = out_q.error;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled while result buffer is empty");

  a_err_notify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.notify == NTF_ERROR) |-> (out_o.error == ERR_UNINIT))
    else $error("error notify without uninitialized error code");

  a_released_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.pressed) |-> (out_o.held_us == '0))
    else $error("hold time reported while released");

  a_lat_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule
